// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL. Synthesis builds define SYNTH.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/lcsu_pkg.sv
package lcsu_pkg;

    localparam int MAX_COLS = 1024;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = 16;
    localparam int CFG_W    = 16;

    typedef logic [7:0]       t_cell;
    typedef logic [COL_W-1:0] t_col;
    typedef logic [ROW_W-1:0] t_row;
    typedef logic [3:0]       t_count;

    localparam t_cell CELL_ALIVE = 8'd0;
    localparam t_cell CELL_DEAD  = 8'd255;

    localparam logic [1:0] REG_GRID_COLS   = 2'd0;
    localparam logic [1:0] REG_GRID_ROWS   = 2'd1;
    localparam logic [1:0] REG_UPDATE_MODE = 2'd2;

    localparam logic [1:0] MODE_FULL  = 2'd0;
    localparam logic [1:0] MODE_DEATH = 2'd1;
    localparam logic [1:0] MODE_BIRTH = 2'd2;

    // Apply the selected rule to the centre byte given its alive-neighbor count.
    function automatic t_cell next_state(input logic [1:0] mode, input t_cell centre,
                                         input t_count n);
        logic lonely_or_crowded;
        logic three;
        t_cell res;
        lonely_or_crowded = (n < 4'd2) || (n > 4'd3);
        three             = (n == 4'd3);
        res               = centre;
        case (mode)
            MODE_DEATH: begin
                if (centre == CELL_ALIVE && lonely_or_crowded) res = CELL_DEAD;
            end
            MODE_BIRTH: begin
                if (centre == CELL_DEAD && three) res = CELL_ALIVE;
            end
            default: begin
                if (lonely_or_crowded) res = CELL_DEAD;
                else if (three) res = CELL_ALIVE;
            end
        endcase
        return res;
    endfunction

endpackage

// File: sv/life_cell_stencil_update.sv
// Channel  | Dir | Signals                         | Beat content
// ---------+-----+---------------------------------+------------------------------
// s_axis   | in  | tvalid tready tdata[7:0]        | cell_in
// m_axis   | out | tvalid tready tdata[7:0] tlast  | next_cell, last
// cfg      | in  | i_cfg_we i_cfg_idx i_cfg_wdata  | 0 grid_cols, 1 grid_rows, 2 mode
//
// One cell is taken per clock unless a result stalls; results pass stage A, then r_out.
// The line store is one 1024 x 16 RAM, read and written once per cycle at distinct
// column addresses, which sets the rate of one cell per cycle.
// Synchronous active-low reset clears counters, window and valids; the RAM is not cleared.
// A stalled result holds the stage behind it; cells without a result never stall.
module life_cell_stencil_update (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  lcsu_pkg::t_cell       s_axis_tdata,   // [7:0] cell_in
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output lcsu_pkg::t_cell       m_axis_tdata,   // [7:0] next_cell
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [lcsu_pkg::CFG_W-1:0] i_cfg_wdata
);
    import lcsu_pkg::*;

    `include "assert_macros.svh"

    // Geometry kept as last index (clamped) and the rule mode
    t_col       r_cols_m1;
    t_row       r_rows_m1;
    logic [1:0] r_mode;

    t_col r_col;
    t_row r_row;

    // Line store: [7:0] row above, [15:8] two rows above
    logic [15:0] mem [MAX_COLS];
    logic [15:0] r_rd;
    logic        mem_re;
    logic        mem_we;
    t_col        mem_ra;
    t_col        mem_wa;
    logic [15:0] mem_wd;

    // Stage A: cell waiting for its line store data
    logic  r_a_valid;
    t_cell r_a_cell;
    t_col  r_a_col;
    logic  r_a_emit;
    logic  r_a_last;

    t_cell r_win [3][3];
    t_cell n_win [3][3];

    logic   in_beat;
    logic   adv_a;
    t_col   c_eff;
    t_row   r_eff;
    logic   col_end;
    logic   row_end;
    t_count alive;

    logic [10:0] cfg_cols;
    logic [15:0] cfg_rows;

    t_cell r_out_data;
    logic  r_out_valid;
    logic  r_out_last;

    assign adv_a         = r_a_valid && (!r_a_emit || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_a_valid || adv_a;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    assign c_eff   = (r_col > r_cols_m1) ? r_cols_m1 : r_col;
    assign r_eff   = (r_row > r_rows_m1) ? r_rows_m1 : r_row;
    assign col_end = (c_eff == r_cols_m1);
    assign row_end = (r_eff == r_rows_m1);

    assign mem_re = in_beat;
    assign mem_ra = c_eff;
    assign mem_we = adv_a;
    assign mem_wa = r_a_col;
    assign mem_wd = {r_rd[7:0], r_a_cell};

    assign cfg_cols = i_cfg_wdata[10:0];
    assign cfg_rows = i_cfg_wdata[15:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (mem_re) r_rd <= mem[mem_ra];
    end

    // Shifted window: new right column is two-above, above, incoming cell
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_win[k][0] = r_win[k][1];
            n_win[k][1] = r_win[k][2];
        end
        n_win[0][2] = r_rd[15:8];
        n_win[1][2] = r_rd[7:0];
        n_win[2][2] = r_a_cell;
    end

    always_comb begin
        alive = '0;
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                if (!(k == 1 && j == 1) && n_win[k][j] == CELL_ALIVE) alive = alive + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_m1 <= t_col'(MAX_COLS - 1);
            r_rows_m1 <= t_row'(1023);
            r_mode    <= MODE_FULL;
            r_col     <= '0;
            r_row     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GRID_COLS: begin
                    if (cfg_cols < 11'd3) r_cols_m1 <= t_col'(2);
                    else if (cfg_cols > 11'(MAX_COLS)) r_cols_m1 <= t_col'(MAX_COLS - 1);
                    else r_cols_m1 <= t_col'(cfg_cols - 11'd1);
                    r_col <= '0;
                    r_row <= '0;
                end
                REG_GRID_ROWS: begin
                    if (cfg_rows < 16'd3) r_rows_m1 <= t_row'(2);
                    else r_rows_m1 <= cfg_rows - 16'd1;
                    r_col <= '0;
                    r_row <= '0;
                end
                REG_UPDATE_MODE: r_mode <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end else if (in_beat) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : r_eff + 16'd1;
            end else begin
                r_col <= c_eff + t_col'(1);
                r_row <= r_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_beat) begin
            r_a_valid <= 1'b1;
        end else if (adv_a) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_a_cell <= s_axis_tdata;
            r_a_col  <= c_eff;
            r_a_emit <= (r_eff >= 16'd2) && (c_eff >= t_col'(2));
            r_a_last <= row_end && col_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) r_win[k][j] <= CELL_DEAD;
            end
        end else if (adv_a) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_a && r_a_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a && r_a_emit) begin
            r_out_data <= next_state(r_mode, n_win[1][1], alive);
            r_out_last <= r_a_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    `ASSERT_IMPLIES(a_ram_no_same_entry, i_clk, i_rst_n, mem_we && mem_re, mem_wa != mem_ra)
    `ASSERT_NEXT(a_emit_gives_beat, i_clk, i_rst_n, adv_a && r_a_emit, m_axis_tvalid)
    `ASSERT_NEXT(a_frame_wrap, i_clk, i_rst_n, in_beat && row_end && col_end && !i_cfg_we, r_col == '0 && r_row == '0)

endmodule
